// ----- sv/json_string_unescape_utf8_macros.svh -----
// Assertion helpers for the string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu check failed");

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu check failed");

`endif

// ----- sv/jsu_pkg.sv -----
package jsu_pkg;

    // Default depth of the request queue between front and back
    localparam int JSU_FIFO_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_NO_OPEN_QUOTE = 4'd1;
    localparam logic [3:0] ERR_CONTROL_CHAR  = 4'd2;
    localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd3;
    localparam logic [3:0] ERR_BAD_HEX       = 4'd4;
    localparam logic [3:0] ERR_LONE_HIGH     = 4'd5;
    localparam logic [3:0] ERR_BAD_LOW       = 4'd6;
    localparam logic [3:0] ERR_UNEXP_LOW     = 4'd7;
    localparam logic [3:0] ERR_UNTERM_STRING = 4'd8;
    localparam logic [3:0] ERR_UNTERM_ESCAPE = 4'd9;
    localparam logic [3:0] ERR_SHORT_UNICODE = 4'd10;

    // One classified request: one to four results of the same kind
    typedef struct packed {
        logic [1:0]      kind;
        logic [3:0]      err;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } jsu_job_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } jsu_q_stat_t;

endpackage

// ----- sv/jsu_fifo.sv -----
module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  jsu_job_t    push_job,
    input  logic        pop,
    output jsu_job_t    pop_job,
    output jsu_q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_job    = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- sv/jsu_front.sv -----
module jsu_front
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_text,
    output logic        push,
    output jsu_job_t    push_job,
    input  jsu_q_stat_t q_stat
);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_STR    = 4'd1;
    localparam logic [3:0] PH_ESC    = 4'd2;
    localparam logic [3:0] PH_HEX1   = 4'd3;
    localparam logic [3:0] PH_WANTBS = 4'd4;
    localparam logic [3:0] PH_WANTU  = 4'd5;
    localparam logic [3:0] PH_HEX2   = 4'd6;

    logic [3:0]  phase_reg, phase_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  high_reg, high_next;
    logic        has_job;
    jsu_job_t    job;
    logic [4:0]  hex;
    logic [15:0] acc_shift;
    logic        accept;

    // {valid, value} of an ASCII hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // UTF-8 encoding of one code point
    function automatic jsu_job_t utf8_job(input logic [20:0] cp);
        jsu_job_t j;
        j      = '0;
        j.kind = KIND_DATA;
        j.err  = ERR_NONE;
        if (cp <= 21'h7F)
        begin
            j.bytes[0] = cp[7:0];
            j.last_idx = 2'd0;
        end
        else if (cp <= 21'h7FF)
        begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end
        else if (cp <= 21'hFFFF)
        begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end
        else
        begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

    function automatic jsu_job_t single_job(input logic [1:0] k, input logic [7:0] b,
                                            input logic [3:0] e);
        jsu_job_t j;
        j          = '0;
        j.kind     = k;
        j.bytes[0] = b;
        j.err      = e;
        j.last_idx = 2'd0;
        return j;
    endfunction

    assign in_ready  = !q_stat.full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && has_job;
    assign push_job  = job;
    assign hex       = hex_value(in_byte);
    assign acc_shift = {acc_reg[11:0], hex[3:0]};

    // classify one byte against the current phase
    always_comb
    begin
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        acc_next     = acc_reg;
        high_next    = high_reg;
        has_job      = 1'b0;
        job          = '0;
        case (phase_reg)
            PH_STR:
            begin
                if (end_of_text)
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_ERR, 8'h00, ERR_UNTERM_STRING);
                end
                else if (in_byte == 8'h22)
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_END, 8'h00, ERR_NONE);
                end
                else if (in_byte < 8'h20)
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_ERR, 8'h00, ERR_CONTROL_CHAR);
                end
                else if (in_byte == 8'h5C)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_DATA, in_byte, ERR_NONE);
                end
            end
            PH_ESC:
            begin
                phase_next = PH_STR;
                has_job    = 1'b1;
                if (end_of_text)
                begin
                    job = single_job(KIND_ERR, 8'h00, ERR_UNTERM_ESCAPE);
                end
                else
                begin
                    case (in_byte)
                        8'h22, 8'h5C, 8'h2F: job = single_job(KIND_DATA, in_byte, ERR_NONE);
                        8'h62: job = single_job(KIND_DATA, 8'h08, ERR_NONE);
                        8'h66: job = single_job(KIND_DATA, 8'h0C, ERR_NONE);
                        8'h6E: job = single_job(KIND_DATA, 8'h0A, ERR_NONE);
                        8'h72: job = single_job(KIND_DATA, 8'h0D, ERR_NONE);
                        8'h74: job = single_job(KIND_DATA, 8'h09, ERR_NONE);
                        8'h75:
                        begin
                            has_job      = 1'b0;
                            phase_next   = PH_HEX1;
                            hex_cnt_next = '0;
                            acc_next     = '0;
                        end
                        default: job = single_job(KIND_ERR, 8'h00, ERR_BAD_ESCAPE);
                    endcase
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                if (end_of_text)
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_ERR, 8'h00, ERR_SHORT_UNICODE);
                end
                else if (!hex[4])
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_ERR, 8'h00, ERR_BAD_HEX);
                end
                else if (hex_cnt_reg != 2'd3)
                begin
                    hex_cnt_next = hex_cnt_reg + 1'b1;
                    acc_next     = acc_shift;
                end
                else
                begin
                    hex_cnt_next = '0;
                    acc_next     = '0;
                    if (phase_reg == PH_HEX1)
                    begin
                        if (acc_shift[15:10] == 6'b110110)
                        begin
                            high_next  = acc_shift[9:0];
                            phase_next = PH_WANTBS;
                        end
                        else if (acc_shift[15:10] == 6'b110111)
                        begin
                            has_job = 1'b1;
                            job     = single_job(KIND_ERR, 8'h00, ERR_UNEXP_LOW);
                        end
                        else
                        begin
                            has_job    = 1'b1;
                            phase_next = PH_STR;
                            job        = utf8_job({5'd0, acc_shift});
                        end
                    end
                    else if (acc_shift[15:10] != 6'b110111)
                    begin
                        has_job = 1'b1;
                        job     = single_job(KIND_ERR, 8'h00, ERR_BAD_LOW);
                    end
                    else
                    begin
                        // surrogate pair: 0x10000 + high bits ++ low bits
                        has_job    = 1'b1;
                        phase_next = PH_STR;
                        job        = utf8_job(21'h10000 + {1'b0, high_reg, acc_shift[9:0]});
                    end
                end
            end
            PH_WANTBS:
            begin
                if (end_of_text || in_byte != 8'h5C)
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_ERR, 8'h00, ERR_LONE_HIGH);
                end
                else
                begin
                    phase_next = PH_WANTU;
                end
            end
            PH_WANTU:
            begin
                if (end_of_text || in_byte != 8'h75)
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_ERR, 8'h00, ERR_LONE_HIGH);
                end
                else
                begin
                    phase_next   = PH_HEX2;
                    hex_cnt_next = '0;
                    acc_next     = '0;
                end
            end
            default:
            begin
                if (end_of_text || in_byte != 8'h22)
                begin
                    has_job = 1'b1;
                    job     = single_job(KIND_ERR, 8'h00, ERR_NO_OPEN_QUOTE);
                end
                else
                begin
                    phase_next = PH_STR;
                end
            end
        endcase
        // end and error both return to idle with the digit state cleared
        if (has_job && job.kind != KIND_DATA)
        begin
            phase_next   = PH_IDLE;
            hex_cnt_next = '0;
            acc_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hex_cnt_reg <= '0;
            acc_reg     <= '0;
            high_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            acc_reg     <= acc_next;
            high_reg    <= high_next;
        end
    end

endmodule

// ----- sv/jsu_back.sv -----
`include "json_string_unescape_utf8_macros.svh"

module jsu_back
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  jsu_job_t    pop_job,
    input  jsu_q_stat_t q_stat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [3:0]  error_code,
    output logic        last
);

    jsu_job_t   job_reg;
    logic       job_valid_reg, job_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [3:0] err_reg;
    logic       last_reg;
    logic       emit;
    logic       is_last;

    // one result per cycle while the output slot drains
    assign emit    = job_valid_reg && (!out_valid_reg || out_ready);
    assign is_last = (idx_reg == job_reg.last_idx);
    assign pop     = !q_stat.empty && (!job_valid_reg || (emit && is_last));

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign out_byte   = byte_reg;
    assign error_code = err_reg;
    assign last       = last_reg;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 1'b1;
            if (is_last)
            begin
                job_valid_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            job_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_job;
        end
        if (emit)
        begin
            kind_reg <= job_reg.kind;
            byte_reg <= job_reg.bytes[idx_reg];
            err_reg  <= job_reg.err;
            last_reg <= is_last;
        end
    end

    `JSU_ASSERT_NOW(a_idx_in_range, job_valid_reg, idx_reg <= job_reg.last_idx)
    `JSU_ASSERT_NOW(a_single_non_data, job_valid_reg && job_reg.kind != KIND_DATA, job_reg.last_idx == 2'd0)
    `JSU_ASSERT_NOW(a_end_err_is_last, out_valid_reg && kind_reg != KIND_DATA, last_reg)
    `JSU_ASSERT_NEXT(a_pop_loads_job, pop, job_valid_reg && idx_reg == 2'd0)

endmodule

// ----- sv/json_string_unescape_utf8.sv -----
// JSON string literal unescaper with UTF-8 output.
// Input channel (in_valid/in_ready): one raw byte of the literal per request,
// starting with the opening quote; end_of_text marks the text exhausted.
// Output channel (out_valid/out_ready): one result per request with kind
// (data byte, clean end, error), out_byte, error_code and last, which flags
// the final result caused by an input byte. A \uXXXX escape or a surrogate
// pair yields 1 to 4 data bytes on the byte that completes it.
// Results pass through the request queue, job register and output register.
// Throughput: one input byte and one result per cycle; the front decoder
// takes a byte every cycle while the request queue (FIFO_DEPTH entries) has
// room, and the output stage drains one result per cycle unless stalled, so
// bytes that expand to several results are absorbed by the queue.
// Reset clears the decoder to idle (awaiting the opening quote) and empties
// the queue and output stage. When the receiver stalls, the queue fills and
// in_ready drops until results are taken again.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int FIFO_DEPTH = JSU_FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [3:0] error_code,
    output logic       last
);

    logic        push;
    logic        pop;
    jsu_job_t    push_job;
    jsu_job_t    pop_job;
    jsu_q_stat_t q_stat;

    jsu_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .push        (push),
        .push_job    (push_job),
        .q_stat      (q_stat)
    );

    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    jsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_job    (pop_job),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .out_byte   (out_byte),
        .error_code (error_code),
        .last       (last)
    );

endmodule
